// ===== src/hrbp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser package
// Shared codes, character constants, result type and the header name table.
// ----------------------------------------------------------------------------
package hrbp_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 32;
   localparam logic [31:0] MAX_BODY_LEN_RESET  = 32'd65535;

   // byte class codes
   localparam logic [2:0] CLS_IGNORED = 3'd0;
   localparam logic [2:0] CLS_METHOD  = 3'd1;
   localparam logic [2:0] CLS_PATH    = 3'd2;
   localparam logic [2:0] CLS_NAME    = 3'd3;
   localparam logic [2:0] CLS_VALUE   = 3'd4;
   localparam logic [2:0] CLS_BODY    = 3'd5;

   // phase codes as seen on the result channel
   localparam logic [1:0] PHASE_REQ_LINE = 2'd0;
   localparam logic [1:0] PHASE_HEADERS  = 2'd1;
   localparam logic [1:0] PHASE_BODY     = 2'd2;
   localparam logic [1:0] PHASE_DONE     = 2'd3;

   // characters
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // length of "Content-Length"
   localparam logic [3:0] NAME_LEN = 4'd14;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  byte_out;
      logic        line_end;
      logic        headers_done;
      logic        request_done;
      logic [31:0] content_length;
      logic        length_error;
      logic [1:0]  phase;
   } hrbp_result_type;

   typedef struct packed {
      logic clear;   // drop the number state (new line or new connection)
      logic feed;    // value byte of a header line
   } hrbp_num_ctrl_type;

   // "Content-Length", one character per index
   function automatic logic [7:0] hrbp_name_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== src/hrbp_ifs.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser channel interfaces
// Valid/ready channels for received bytes and for classified result items.
// ----------------------------------------------------------------------------
interface hrbp_req_if;
   logic       valid;
   logic       ready;
   logic       conn_start;
   logic [7:0] byte_in;

   modport source (output valid, output conn_start, output byte_in, input ready);
   modport sink   (input valid, input conn_start, input byte_in, output ready);
endinterface

interface hrbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_class;
   logic [7:0]  byte_out;
   logic        line_end;
   logic        headers_done;
   logic        request_done;
   logic [31:0] content_length;
   logic        length_error;
   logic [1:0]  phase;

   modport source (output valid, output byte_class, output byte_out, output line_end,
                   output headers_done, output request_done, output content_length,
                   output length_error, output phase, input ready);
   modport sink   (input valid, input byte_class, input byte_out, input line_end,
                   input headers_done, input request_done, input content_length,
                   input length_error, input phase, output ready);
endinterface

// ===== src/hrbp_num_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser length number unit
// atoi-style decimal accumulator for the Content-Length value, with commit.
// ----------------------------------------------------------------------------
module hrbp_num_unit
   import hrbp_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  hrbp_num_ctrl_type      ctrl,
   input  logic [7:0]             byte_in,
   input  logic [LENGTH_BITS-1:0] limit,
   output logic [LENGTH_BITS-1:0] commit_value,
   output logic                   commit_error
);

   localparam int unsigned PW = LENGTH_BITS + 4;

   typedef enum logic [3:0] {
      NUM_SKIP   = 4'b0001,
      NUM_SIGN   = 4'b0010,
      NUM_DIGITS = 4'b0100,
      NUM_END    = 4'b1000
   } num_stage_type;

   num_stage_type          stage_ff, stage_in;
   logic                   negative_ff, negative_in;
   logic                   overflow_ff, overflow_in;
   logic [LENGTH_BITS-1:0] accum_ff, accum_in;

   logic          is_blank, is_sign, is_digit, go_digits;
   logic [3:0]    digit;
   logic [PW-1:0] product;

   assign is_blank = (byte_in == CH_SPACE) || (byte_in == CH_TAB) ||
                     (byte_in == CH_VT) || (byte_in == CH_FF);
   assign is_sign  = (byte_in == CH_MINUS) || (byte_in == CH_PLUS);
   assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign digit    = 4'(byte_in - CH_ZERO);

   // accum * 10 + digit, compared against the limit in place
   assign product = PW'(accum_ff) * PW'(4'd10) + PW'(digit);

   always_comb begin
      stage_in    = stage_ff;
      negative_in = negative_ff;
      overflow_in = overflow_ff;
      accum_in    = accum_ff;
      go_digits   = 1'b0;
      if (ctrl.clear) begin
         stage_in    = NUM_SKIP;
         negative_in = 1'b0;
         overflow_in = 1'b0;
         accum_in    = '0;
      end else if (ctrl.feed) begin
         unique case (stage_ff)
            NUM_SKIP: begin
               if (is_sign) begin
                  negative_in = (byte_in == CH_MINUS);
                  stage_in    = NUM_SIGN;
               end else if (!is_blank) begin
                  go_digits = 1'b1;
               end
            end
            NUM_SIGN, NUM_DIGITS: begin
               go_digits = 1'b1;
            end
            NUM_END: begin
               go_digits = 1'b0;
            end
            default: begin
               go_digits = 1'b0;
            end
         endcase
         if (go_digits) begin
            if (is_digit) begin
               stage_in = NUM_DIGITS;
               if (!overflow_ff) begin
                  if (product > PW'(limit)) begin
                     overflow_in = 1'b1;
                  end else begin
                     accum_in = product[LENGTH_BITS-1:0];
                  end
               end
            end else begin
               stage_in = NUM_END;
            end
         end
      end
   end

   // limit may have moved since the digits came in, so compare again
   assign commit_error = overflow_ff || (accum_ff > limit) ||
                         (negative_ff && (accum_ff != '0));
   assign commit_value = commit_error ? limit : accum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= NUM_SKIP;
         negative_ff <= 1'b0;
         overflow_ff <= 1'b0;
         accum_ff    <= '0;
      end else if (step) begin
         stage_ff    <= stage_in;
         negative_ff <= negative_in;
         overflow_ff <= overflow_in;
         accum_ff    <= accum_in;
      end
   end

endmodule

// ===== src/hrbp_core.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser core
// Per-byte parse state update and classification, one byte per step.
// ----------------------------------------------------------------------------
module hrbp_core
   import hrbp_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   conn_start,
   input  logic [7:0]             byte_in,
   input  logic [LENGTH_BITS-1:0] limit,
   output hrbp_result_type        result
);

   typedef enum logic [3:0] {
      PH_REQ_LINE = 4'b0001,
      PH_HEADERS  = 4'b0010,
      PH_BODY     = 4'b0100,
      PH_DONE     = 4'b1000
   } phase_type;

   phase_type              phase_ff, phase_in, cur_phase;
   logic [1:0]             space_count_ff, space_count_in, cur_space_count;
   logic                   after_colon_ff, after_colon_in, cur_after_colon;
   logic                   first_space_ff, first_space_in, cur_first_space;
   logic                   name_seen_ff, name_seen_in, cur_name_seen;
   logic                   line_stopped_ff, line_stopped_in, cur_line_stopped;
   logic [3:0]             match_index_ff, match_index_in, cur_match_index;
   logic                   match_failed_ff, match_failed_in, cur_match_failed;
   logic [LENGTH_BITS-1:0] length_value_ff, length_value_in, cur_length_value;
   logic [LENGTH_BITS-1:0] body_count_ff, body_count_in, cur_body_count;
   logic                   error_flag_ff, error_flag_in, cur_error_flag;

   logic [LENGTH_BITS-1:0] body_count_inc;
   logic [LENGTH_BITS-1:0] commit_value;
   logic                   commit_error;
   logic                   clear_line;
   logic                   feed;
   logic [2:0]             cls;
   logic                   lend, hdone, rdone;
   logic [1:0]             phase_code;
   hrbp_num_ctrl_type      num_ctrl;

   // a new connection starts from the reset state
   assign cur_phase        = conn_start ? PH_REQ_LINE : phase_ff;
   assign cur_space_count  = conn_start ? 2'd0 : space_count_ff;
   assign cur_after_colon  = conn_start ? 1'b0 : after_colon_ff;
   assign cur_first_space  = conn_start ? 1'b0 : first_space_ff;
   assign cur_name_seen    = conn_start ? 1'b0 : name_seen_ff;
   assign cur_line_stopped = conn_start ? 1'b0 : line_stopped_ff;
   assign cur_match_index  = conn_start ? 4'd0 : match_index_ff;
   assign cur_match_failed = conn_start ? 1'b0 : match_failed_ff;
   assign cur_length_value = conn_start ? '0 : length_value_ff;
   assign cur_body_count   = conn_start ? '0 : body_count_ff;
   assign cur_error_flag   = conn_start ? 1'b0 : error_flag_ff;

   assign body_count_inc = cur_body_count + LENGTH_BITS'(1);

   always_comb begin
      phase_in        = cur_phase;
      space_count_in  = cur_space_count;
      after_colon_in  = cur_after_colon;
      first_space_in  = cur_first_space;
      name_seen_in    = cur_name_seen;
      line_stopped_in = cur_line_stopped;
      match_index_in  = cur_match_index;
      match_failed_in = cur_match_failed;
      length_value_in = cur_length_value;
      body_count_in   = cur_body_count;
      error_flag_in   = cur_error_flag;
      clear_line      = 1'b0;
      feed            = 1'b0;
      cls             = CLS_IGNORED;
      lend            = 1'b0;
      hdone           = 1'b0;
      rdone           = 1'b0;

      unique case (cur_phase)
         PH_REQ_LINE: begin
            if (byte_in == CH_SPACE) begin
               if (cur_space_count < 2'd2) begin
                  space_count_in = cur_space_count + 2'd1;
               end
            end else if (cur_space_count == 2'd0) begin
               cls = CLS_METHOD;
            end else if (cur_space_count == 2'd1) begin
               cls = CLS_PATH;
            end
            if (byte_in == CH_LF) begin
               lend       = 1'b1;
               phase_in   = PH_HEADERS;
               clear_line = 1'b1;
            end
         end
         PH_HEADERS: begin
            if (byte_in == CH_LF) begin
               lend       = 1'b1;
               clear_line = 1'b1;
               if (!cur_name_seen) begin
                  hdone = 1'b1;
                  if (cur_length_value != '0) begin
                     phase_in = PH_BODY;
                  end else begin
                     phase_in = PH_DONE;
                     rdone    = 1'b1;
                  end
               end else if (!cur_match_failed && (cur_match_index == NAME_LEN)) begin
                  length_value_in = commit_value;
                  error_flag_in   = commit_error;
               end
            end else if (cur_line_stopped) begin
               cls = CLS_IGNORED;
            end else if (byte_in == CH_CR) begin
               line_stopped_in = 1'b1;
            end else if (!cur_after_colon) begin
               if (byte_in == CH_COLON) begin
                  after_colon_in = 1'b1;
                  first_space_in = 1'b1;
               end else begin
                  cls          = CLS_NAME;
                  name_seen_in = 1'b1;
                  if (!cur_match_failed) begin
                     if ((cur_match_index >= NAME_LEN) ||
                         (hrbp_name_char(cur_match_index) != byte_in)) begin
                        match_failed_in = 1'b1;
                     end else begin
                        match_index_in = cur_match_index + 4'd1;
                     end
                  end
               end
            end else if ((byte_in == CH_SPACE) && cur_first_space) begin
               first_space_in = 1'b0;
            end else begin
               cls  = CLS_VALUE;
               feed = 1'b1;
            end
         end
         PH_BODY: begin
            cls           = CLS_BODY;
            body_count_in = body_count_inc;
            if (body_count_inc >= cur_length_value) begin
               rdone    = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            cls = CLS_IGNORED;
         end
         default: begin
            cls = CLS_IGNORED;
         end
      endcase

      if (clear_line) begin
         space_count_in  = 2'd0;
         after_colon_in  = 1'b0;
         first_space_in  = 1'b0;
         name_seen_in    = 1'b0;
         line_stopped_in = 1'b0;
         match_index_in  = 4'd0;
         match_failed_in = 1'b0;
      end
   end

   assign num_ctrl.clear = conn_start || clear_line;
   assign num_ctrl.feed  = feed;

   hrbp_num_unit #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_num (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .ctrl         (num_ctrl),
      .byte_in      (byte_in),
      .limit        (limit),
      .commit_value (commit_value),
      .commit_error (commit_error)
   );

   always_comb begin
      unique case (phase_in)
         PH_REQ_LINE: phase_code = PHASE_REQ_LINE;
         PH_HEADERS:  phase_code = PHASE_HEADERS;
         PH_BODY:     phase_code = PHASE_BODY;
         PH_DONE:     phase_code = PHASE_DONE;
         default:     phase_code = PHASE_REQ_LINE;
      endcase
   end

   assign result.byte_class     = cls;
   assign result.byte_out       = byte_in;
   assign result.line_end       = lend;
   assign result.headers_done   = hdone;
   assign result.request_done   = rdone;
   assign result.content_length = 32'(length_value_in);
   assign result.length_error   = error_flag_in;
   assign result.phase          = phase_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_REQ_LINE;
         space_count_ff  <= 2'd0;
         after_colon_ff  <= 1'b0;
         first_space_ff  <= 1'b0;
         name_seen_ff    <= 1'b0;
         line_stopped_ff <= 1'b0;
         match_index_ff  <= 4'd0;
         match_failed_ff <= 1'b0;
         length_value_ff <= '0;
         body_count_ff   <= '0;
         error_flag_ff   <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         space_count_ff  <= space_count_in;
         after_colon_ff  <= after_colon_in;
         first_space_ff  <= first_space_in;
         name_seen_ff    <= name_seen_in;
         line_stopped_ff <= line_stopped_in;
         match_index_ff  <= match_index_in;
         match_failed_ff <= match_failed_in;
         length_value_ff <= length_value_in;
         body_count_ff   <= body_count_in;
         error_flag_ff   <= error_flag_in;
      end
   end

endmodule

// ===== src/http_request_byte_parser_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser unit
// Labels each received byte of one connection as method, path, header name,
// header value, body or ignored, and tracks the Content-Length body.
//
// Usage:
//  - req_chan carries one received byte per item, with conn_start set on the
//    first byte of a new connection (clears all parse state first).
//  - rsp_chan returns exactly one result item per byte, in order.
//  - csr_wr_en / csr_wr_data write max_body_len; write only while idle.
//  - Path: a byte taken into the input register goes through the parse logic
//    into the result register, and from there onto rsp_chan.
//  - Throughput: one item per cycle unless rsp_chan stalls; each byte's
//    update is a single pass through the parse logic and the length digit multiply-add.
//  - If rsp_chan stalls, the result register holds its item and the input
//    register still takes one more byte; req_chan.ready then drops.
//  - Reset: both channels empty, parse state at start of a request line,
//    max_body_len = 65535.
// ----------------------------------------------------------------------------
module http_request_byte_parser_unit
   import hrbp_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hrbp_req_if.sink    req_chan,
   hrbp_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   // all-ones at LENGTH_BITS, as a 32-bit value
   localparam logic [31:0] LIMIT_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

   logic [31:0] max_len_ff;
   logic [31:0] limit_full;
   logic [LENGTH_BITS-1:0] limit;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_conn_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic            out_valid_ff, out_valid_in;
   hrbp_result_type out_ff;
   hrbp_result_type result;

   logic advance;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_BODY_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign limit_full = (max_len_ff > LIMIT_MASK) ? LIMIT_MASK : max_len_ff;
   assign limit      = limit_full[LENGTH_BITS-1:0];

   // a byte moves through the parser when the result register is free
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_conn_ff <= req_chan.conn_start;
         in_byte_ff <= req_chan.byte_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   hrbp_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .conn_start (in_conn_ff),
      .byte_in    (in_byte_ff),
      .limit      (limit),
      .result     (result)
   );

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.byte_class     = out_ff.byte_class;
   assign rsp_chan.byte_out       = out_ff.byte_out;
   assign rsp_chan.line_end       = out_ff.line_end;
   assign rsp_chan.headers_done   = out_ff.headers_done;
   assign rsp_chan.request_done   = out_ff.request_done;
   assign rsp_chan.content_length = out_ff.content_length;
   assign rsp_chan.length_error   = out_ff.length_error;
   assign rsp_chan.phase          = out_ff.phase;

endmodule

// ===== tb/http_request_byte_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request byte parser unit testbench
// Streams request bytes through the parser under random idles and long
// back-pressure. A behavioral copy of the parser predicts each result item,
// and every returned item is checked field by field, in order.
// ----------------------------------------------------------------------------
module http_request_byte_parser_unit_tb;
   import hrbp_pkg::*;

   localparam int unsigned TB_LENGTH_BITS = LENGTH_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake or register write
   localparam int TOTAL_ITEMS    = 1350;   // byte budget for the whole run
   localparam int BODY_SEND_MAX  = 48;     // longer bodies are cut short
   localparam logic [8*14-1:0] CL_NAME_TEXT = "Content-Length";

   // atoi-style number scan of a Content-Length value
   typedef enum logic [3:0] {
      NUM_SKIP_WS = 4'b0001,
      NUM_START   = 4'b0010,
      NUM_DIGITS  = 4'b0100,
      NUM_END     = 4'b1000
   } num_stage_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   hrbp_req_if req_if ();
   hrbp_rsp_if rsp_if ();

   http_request_byte_parser_unit #(.LENGTH_BITS(TB_LENGTH_BITS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Parser mirror: register copy plus per-connection parse state
   // ------------------------------------------------------------------------
   logic [31:0]   body_limit;
   logic [1:0]    rx_phase;
   logic [1:0]    rx_spaces;
   logic          rx_in_value;      // colon seen on this header line
   logic          rx_skip_space;    // first space of the value still to drop
   logic          rx_name_seen;
   logic          rx_cr_seen;       // rest of the line up to LF is ignored
   logic [3:0]    rx_match_pos;
   logic          rx_mismatch;
   num_stage_type rx_num;
   logic          rx_minus;
   logic          rx_too_big;
   logic [31:0]   rx_digits;
   logic [31:0]   rx_length;
   logic [31:0]   rx_body_seen;
   logic          rx_len_err;

   hrbp_result_type pending_results[$];

   // run bookkeeping
   int  mismatches       = 0;
   int  bytes_sent       = 0;
   int  active_items     = 0;   // items the parser did not just ignore
   int  results_seen     = 0;
   int  requests_done    = 0;
   int  saturations      = 0;
   int  limits_written   = 0;
   int  longest_hold     = 0;
   int  send_gap_max     = 6;
   int  recv_gap_max     = 6;
   int  hold_off_cycles  = 0;
   int  stall_cycles     = 0;
   logic new_conn        = 1'b0;

   function automatic logic [31:0] length_cap();
      logic [63:0] cap;
      cap = (64'd1 << TB_LENGTH_BITS) - 64'd1;
      return ({32'd0, body_limit} > cap) ? cap[31:0] : body_limit;
   endfunction

   function automatic void clear_line();
      rx_spaces     = '0;
      rx_in_value   = 1'b0;
      rx_skip_space = 1'b0;
      rx_name_seen  = 1'b0;
      rx_cr_seen    = 1'b0;
      rx_match_pos  = '0;
      rx_mismatch   = 1'b0;
      rx_num        = NUM_SKIP_WS;
      rx_minus      = 1'b0;
      rx_digits     = '0;
      rx_too_big    = 1'b0;
   endfunction

   function automatic void clear_connection();
      rx_phase     = PHASE_REQ_LINE;
      clear_line();
      rx_length    = '0;
      rx_body_seen = '0;
      rx_len_err   = 1'b0;
   endfunction

   function automatic logic [7:0] cl_name_char(input logic [3:0] pos);
      int idx;
      idx = int'(pos);
      return CL_NAME_TEXT[8*(13 - idx) +: 8];
   endfunction

   function automatic void scan_value_char(input logic [7:0] b);
      logic [63:0] wide;
      if (rx_num == NUM_SKIP_WS) begin
         if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) return;
         if (b == CH_MINUS || b == CH_PLUS) begin
            rx_minus = (b == CH_MINUS);
            rx_num   = NUM_START;
            return;
         end
         rx_num = NUM_START;
      end
      if (rx_num == NUM_START || rx_num == NUM_DIGITS) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            rx_num = NUM_DIGITS;
            if (!rx_too_big) begin
               wide = {32'd0, rx_digits} * 64'd10 + {56'd0, b - CH_ZERO};
               // once over the limit the digits stop accumulating
               if (wide > {32'd0, length_cap()}) rx_too_big = 1'b1;
               else rx_digits = wide[31:0];
            end
         end else begin
            rx_num = NUM_END;
         end
      end
   endfunction

   function automatic void commit_length();
      logic [31:0] cap;
      cap = length_cap();
      if (rx_too_big || rx_digits > cap || (rx_minus && rx_digits != 0)) begin
         rx_length  = cap;
         rx_len_err = 1'b1;
         saturations++;
      end else begin
         rx_length  = rx_digits;
         rx_len_err = 1'b0;
      end
   endfunction

   // One byte in, one result item out; updates the mirror state.
   function automatic hrbp_result_type classify_byte(input logic start,
                                                     input logic [7:0] b);
      hrbp_result_type r;
      r            = '0;
      r.byte_out   = b;
      r.byte_class = CLS_IGNORED;
      if (start) clear_connection();
      case (rx_phase)
         PHASE_REQ_LINE: begin
            // method up to the first space, path up to the second
            if (b == CH_SPACE) begin
               if (rx_spaces < 2) rx_spaces++;
            end else if (rx_spaces == 0) begin
               r.byte_class = CLS_METHOD;
            end else if (rx_spaces == 1) begin
               r.byte_class = CLS_PATH;
            end
            if (b == CH_LF) begin
               r.line_end = 1'b1;
               rx_phase   = PHASE_HEADERS;
               clear_line();
            end
         end
         PHASE_HEADERS: begin
            if (b == CH_LF) begin
               r.line_end = 1'b1;
               if (!rx_name_seen) begin
                  r.headers_done = 1'b1;
                  if (rx_length > 0) begin
                     rx_phase = PHASE_BODY;
                  end else begin
                     rx_phase       = PHASE_DONE;
                     r.request_done = 1'b1;
                  end
               end else if (!rx_mismatch && rx_match_pos == NAME_LEN) begin
                  commit_length();
               end
               clear_line();
            end else if (rx_cr_seen) begin
               r.byte_class = CLS_IGNORED;
            end else if (b == CH_CR) begin
               rx_cr_seen = 1'b1;
            end else if (!rx_in_value) begin
               if (b == CH_COLON) begin
                  rx_in_value   = 1'b1;
                  rx_skip_space = 1'b1;
               end else begin
                  r.byte_class = CLS_NAME;
                  rx_name_seen = 1'b1;
                  if (!rx_mismatch) begin
                     if (rx_match_pos >= NAME_LEN || cl_name_char(rx_match_pos) != b)
                        rx_mismatch = 1'b1;
                     else
                        rx_match_pos++;
                  end
               end
            end else if (b == CH_SPACE && rx_skip_space) begin
               rx_skip_space = 1'b0;
            end else begin
               r.byte_class = CLS_VALUE;
               scan_value_char(b);
            end
         end
         PHASE_BODY: begin
            r.byte_class = CLS_BODY;
            rx_body_seen++;
            if (rx_body_seen >= rx_length) begin
               r.request_done = 1'b1;
               rx_phase       = PHASE_DONE;
            end
         end
         default: begin
            // done: everything ignored until the next connection
         end
      endcase
      r.content_length = rx_length;
      r.length_error   = rx_len_err;
      r.phase          = rx_phase;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side: one item per call, random idle before it
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic start, input logic [7:0] b);
      int gap;
      hrbp_result_type want;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.conn_start <= start;
      req_if.byte_in    <= b;
      do @(posedge clock); while (!req_if.ready);
      // accepted at this edge: predict now, before the next item goes out
      want = classify_byte(start, b);
      pending_results.push_back(want);
      bytes_sent++;
      if (want.byte_class != CLS_IGNORED || want.line_end) active_items++;
      if (want.request_done) requests_done++;
   endtask

   task automatic begin_connection();
      new_conn = 1'b1;
   endtask

   task automatic put_byte(input logic [7:0] b);
      send_byte(new_conn, b);
      new_conn = 1'b0;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_number(input longint unsigned v);
      put_text($sformatf("%0d", v));
   endtask

   task automatic put_crlf();
      put_byte(CH_CR);
      put_byte(CH_LF);
   endtask

   // Drop valid and hold off until every expected result item is back.
   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic set_body_limit(input logic [31:0] value);
      pause_until_drained();
      repeat (3) @(posedge clock);   // input and result registers go empty
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      body_limit = value;
      limits_written++;
   endtask

   // ------------------------------------------------------------------------
   // Receiver side and result check
   // ------------------------------------------------------------------------
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: result %0d %s expected %0h actual %0h",
                  $time, results_seen, field, want, got);
      end
   endtask

   task automatic check_result();
      hrbp_result_type want;
      results_seen++;
      if (pending_results.size() == 0) begin
         mismatches++;
         $display("%0t ns: result item with nothing expected, expected none actual byte %0h",
                  $time, rsp_if.byte_out);
      end else begin
         want = pending_results.pop_front();
         check_field("byte_class",     want.byte_class,     rsp_if.byte_class);
         check_field("byte_out",       want.byte_out,       rsp_if.byte_out);
         check_field("line_end",       want.line_end,       rsp_if.line_end);
         check_field("headers_done",   want.headers_done,   rsp_if.headers_done);
         check_field("request_done",   want.request_done,   rsp_if.request_done);
         check_field("content_length", want.content_length, rsp_if.content_length);
         check_field("length_error",   want.length_error,   rsp_if.length_error);
         check_field("phase",          want.phase,          rsp_if.phase);
      end
   endtask

   initial begin : result_sink
      int gap;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // a requested long hold-off replaces the usual random idle once
         if (hold_off_cycles > 0) begin
            gap = hold_off_cycles;
            hold_off_cycles = 0;
            if (gap > longest_hold) longest_hold = gap;
         end else begin
            gap = $urandom_range(recv_gap_max, 0);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         check_result();
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            $display("http_request_byte_parser_unit_tb: errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Random stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255, 0));
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'($urandom_range(8'h5A, 8'h41));
   endfunction

   function automatic logic [7:0] rand_printable();
      return 8'($urandom_range(8'h7E, 8'h21));   // no space
   endfunction

   // Line end: mostly CRLF, sometimes bare LF or junk between CR and LF.
   task automatic put_eol();
      case ($urandom_range(9, 0))
         0: put_byte(CH_LF);
         1: begin
            put_byte(CH_CR);
            repeat ($urandom_range(3, 1)) put_byte(rand_byte());
            put_byte(CH_LF);
         end
         default: put_crlf();
      endcase
   endtask

   // Content-Length value: blanks, sign, digits of many shapes, trailing junk.
   task automatic put_length_text();
      int pick;
      repeat ($urandom_range(2, 0)) begin
         case ($urandom_range(3, 0))
            0: put_byte(CH_SPACE);
            1: put_byte(CH_TAB);
            2: put_byte(CH_VT);
            default: put_byte(CH_FF);
         endcase
      end
      pick = $urandom_range(9, 0);
      if (pick == 0) put_byte(CH_MINUS);
      else if (pick == 1) put_byte(CH_PLUS);
      case ($urandom_range(9, 0))
         0: begin
            // no digits at all
         end
         1: put_text("99999999999");
         2: put_number({32'd0, body_limit});
         3: put_number({32'd0, body_limit} + 64'd1);
         4: begin
            put_text("000");
            put_number($urandom_range(30, 0));
         end
         default: put_number($urandom_range(30, 0));
      endcase
      if ($urandom_range(4, 0) == 0) begin
         put_byte(rand_printable());
         put_number($urandom_range(9, 0));
      end
   endtask

   task automatic random_header();
      int kind, count;
      logic [7:0] c;
      kind = $urandom_range(19, 0);
      if (kind < 8) begin
         put_text("Content-Length:");
         put_length_text();
      end else if (kind == 8) begin
         put_text("Content-Length");            // no colon, empty value
      end else if (kind == 9) begin
         case ($urandom_range(2, 0))
            0: put_text("Content-Lengt: 4");
            1: put_text("Content-Lengths: 4");
            default: put_text("content-length: 4");
         endcase
      end else if (kind == 10) begin
         put_text(":v");                        // empty name ends the headers
      end else begin
         count = $urandom_range(10, 1);
         repeat (count) put_byte(($urandom_range(5, 0) == 0) ? CH_MINUS : rand_letter());
         put_byte(CH_COLON);
         count = $urandom_range(12, 0);
         repeat (count) begin
            case ($urandom_range(7, 0))
               0, 1: c = CH_SPACE;
               2:    c = CH_COLON;
               default: c = rand_printable();
            endcase
            put_byte(c);
         end
      end
      put_eol();
   endtask

   // A request with random content; sometimes broken off or with trailing bytes.
   task automatic random_request();
      int count, kind;
      logic [31:0] len;
      begin_connection();
      count = $urandom_range(6, 1);
      repeat (count) put_byte(rand_letter());
      kind = $urandom_range(19, 0);
      if (kind != 0) begin
         put_byte(CH_SPACE);
         put_byte("/");
         count = $urandom_range(8, 0);
         repeat (count) put_byte(rand_printable());
         if (kind > 3) put_text(" HTTP/1.1");
         if (kind == 2) put_text("  x y");
      end
      put_eol();
      count = $urandom_range(4, 0);
      repeat (count) random_header();
      if ($urandom_range(9, 0) != 0) put_eol();   // blank line ends headers
      if (rx_phase == PHASE_BODY) begin
         len = rx_length;
         if (len > BODY_SEND_MAX) len = BODY_SEND_MAX;
         else if ($urandom_range(9, 0) == 0) len = len / 2;   // connection drops early
         repeat (len) put_byte(rand_byte());
      end
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(4, 1)) put_byte(rand_byte());
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(8, 1)) send_byte($urandom_range(3, 0) == 0, rand_byte());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Request line: no space, one space, two spaces; byte extremes when done.
   task automatic test_request_line();
      begin_connection();
      put_text("G");
      put_crlf();                 // CR and LF still count as method
      put_byte(CH_LF);            // empty header line, zero length: done
      put_byte(8'hFF);
      put_byte(8'h00);
      begin_connection();
      put_text("M /");
      put_crlf();                 // CR and LF now count as path
      put_text("Host:x");
      put_crlf();
      put_crlf();
      begin_connection();
      put_text("GET /p  HTTP/1.1");
      put_crlf();
      put_byte(CH_LF);
   endtask

   // Header quirks under the reset limit.
   task automatic test_header_fields();
      begin_connection();
      put_text("P /");
      put_crlf();
      put_text("Content-Length:  +12");   // one space dropped, one skipped
      put_crlf();
      put_text("X-A:a b  c");
      put_byte(CH_CR);
      put_text("junk: 7");                // ignored after CR
      put_byte(CH_LF);
      put_text("Content-Length");         // no colon commits zero
      put_crlf();
      put_text("Content-Length:-5");      // negative saturates with error
      put_crlf();
      put_text("Content-Length:");        // no digits: zero, error cleared
      put_crlf();
      put_text("content-length: 9");
      put_crlf();
      put_text("Content-Lengthy: 9");
      put_crlf();
      put_text("Content-Length: -0");
      put_crlf();
      put_text("Content-Length: 3x7");    // digits stop at the x
      put_crlf();
      put_crlf();
      put_text("abc");
      put_text("z");                      // after the last body byte
   endtask

   // Register extremes: zero, all ones, a small limit, then back to reset.
   task automatic test_length_limits();
      set_body_limit(32'd0);
      begin_connection();
      put_text("Q /");
      put_crlf();
      put_text("Content-Length: 1");
      put_crlf();
      put_crlf();

      set_body_limit(32'hFFFF_FFFF);
      begin_connection();
      put_text("Q /");
      put_crlf();
      put_text("Content-Length: 4294967295");
      put_crlf();
      put_text("Content-Length: 4294967296");   // overflows while scanning
      put_crlf();
      put_text("Content-Length:00000000000000000002");
      put_crlf();
      put_text("Content-Length:");
      put_byte(CH_TAB);
      put_byte(CH_VT);
      put_byte(CH_FF);
      put_text(" 2");
      put_crlf();
      put_crlf();
      put_text("hi");

      set_body_limit(32'd10);
      begin_connection();
      put_text("Q /");
      put_crlf();
      put_text("Content-Length: 11");      // one above the limit
      put_crlf();
      put_text("Content-Length: 100");     // well over the limit
      put_crlf();
      put_text("Content-Length: 10");
      put_crlf();
      put_crlf();
      repeat (5) begin
         put_byte(8'h00);
         put_byte(8'hFF);
      end
      set_body_limit(MAX_BODY_LEN_RESET);
   endtask

   // Receiver holds off while the sender streams; the block must stall its input.
   task automatic test_backpressure();
      send_gap_max    = 0;
      recv_gap_max    = 0;
      hold_off_cycles = 150;
      begin_connection();
      put_text("POST /upload HTTP/1.1");
      put_crlf();
      put_text("Content-Length: 5");
      put_crlf();
      put_crlf();
      put_text("hello");
      pause_until_drained();
      send_gap_max = 6;
      recv_gap_max = 6;
      random_request();
      pause_until_drained();
   endtask

   // Mostly well-formed requests with random content, swept over limits.
   task automatic test_random_requests();
      logic [31:0] limit_set [7] = '{32'd30, 32'd0, 32'hFFFF_FFFF, 32'd1,
                                     32'd1000, MAX_BODY_LEN_RESET, 32'd0};
      int goal, share;
      limit_set[6] = $urandom;
      // the rest of the byte budget, split evenly over the limits
      share = (TOTAL_ITEMS - bytes_sent) / 7;
      foreach (limit_set[k]) begin
         set_body_limit(limit_set[k]);
         goal = bytes_sent + share;
         while (bytes_sent < goal) begin
            // per request: each side idles at random before each item, or not at all
            send_gap_max = ($urandom_range(1, 0) == 1) ? 6 : 0;
            recv_gap_max = ($urandom_range(1, 0) == 1) ? 6 : 0;
            if ($urandom_range(9, 0) == 0) noise_burst();
            else random_request();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid      = 1'b0;
      req_if.conn_start = 1'b0;
      req_if.byte_in    = '0;
      body_limit        = MAX_BODY_LEN_RESET;
      clear_connection();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_request_line();
      test_header_fields();
      test_length_limits();
      test_backpressure();
      test_random_requests();

      pause_until_drained();
      repeat (8) @(posedge clock);   // catch any stray result items

      $display("run covered %0d bytes (%0d parsed), %0d results, %0d requests completed",
               bytes_sent, active_items, results_seen, requests_done);
      $display("%0d saturated lengths, %0d limit writes, longest receiver hold %0d cycles",
               saturations, limits_written, longest_hold);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("http_request_byte_parser_unit_tb: clean");
      end else begin
         $display("http_request_byte_parser_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hrbp_pkg.sv
src/hrbp_ifs.sv
src/hrbp_num_unit.sv
src/hrbp_core.sv
src/http_request_byte_parser_unit.sv
tb/http_request_byte_parser_unit_tb.sv
